// ===== src/upet_pkg.sv =====
// Shared constants and types for the ultrasonic ping / echo timer.
// Used by the result channel interface and the top level; no dependencies.

package upet_pkg;

    localparam int TIME_W  = 16;          // width of the microsecond registers
    localparam int COUNT_W = TIME_W + 1;  // tick counter, one spare bit to pass any deadline

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ECHO_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIMEOUT = 2'd2;

    localparam logic [TIME_W-1:0] MAX_ECHO_RESET      = 16'd30000;
    localparam logic [TIME_W-1:0] START_TIMEOUT_RESET = 16'd18000;

    localparam logic [COUNT_W-1:0] TRIG_LOW_TICKS  = 17'd4;
    localparam logic [COUNT_W-1:0] TRIG_HIGH_TICKS = 17'd10;
    localparam logic [COUNT_W-1:0] ECHO_OVERHEAD   = 17'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 17'h10000;

    localparam int PHASE_W = 3;
    typedef logic [PHASE_W-1:0] phase_t;

endpackage

// ===== src/upet_tick_if.sv =====
// Input channel of the ping / echo timer: one microsecond tick per item.
// Depends on nothing.

interface upet_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

// ===== src/upet_result_if.sv =====
// Output channel of the ping / echo timer: one result item per tick.
// Depends on upet_pkg for the time width.

interface upet_result_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger_level;
    logic                        busy_res;
    logic                        done_res;
    logic                        no_echo;
    logic [upet_pkg::TIME_W-1:0] echo_time_us;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output no_echo, output echo_time_us, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input no_echo, input echo_time_us, output ready);
endinterface

// ===== src/ultrasonic_ping_echo_timer.sv =====
// Ultrasonic ping / echo pulse timer, top level.
// Depends on upet_pkg, upet_tick_if and upet_result_if.
//
// Usage:
//   Feed one item on the tick channel for every microsecond: the sampled echo
//   pin level and a start request. Each item gives exactly one item on the
//   result channel: the trigger pin level, busy, done, no_echo and the last
//   measured echo time. A start taken while enabled and idle drives the
//   trigger low for 4 ticks and high for 10, then waits for the echo to clear
//   and rise within start_timeout_us, then times the high pulse.
//   The result of an item is presented in the cycle after it is accepted.
//   One item can be accepted in every cycle while result.ready is high; the
//   phase and the 17-bit tick counter are updated with every accepted item.
//   The result register is the only buffer, so tick.ready drops only while a
//   result is held and result.ready is low; the state does not advance then.
//   Registers are written through cfg_we / cfg_index / cfg_data and act from
//   the next item. Reset clears the phase, counter and stored echo time and
//   loads the register defaults (disabled, 30000 us, 18000 us).

module ultrasonic_ping_echo_timer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [upet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [upet_pkg::TIME_W-1:0]    cfg_data,
    upet_tick_if.sink                      tick,
    upet_result_if.source                  result
);
    import upet_pkg::*;

    localparam phase_t PH_IDLE    = 3'd0;
    localparam phase_t PH_TLOW    = 3'd1;
    localparam phase_t PH_THIGH   = 3'd2;
    localparam phase_t PH_CLEAR   = 3'd3;
    localparam phase_t PH_RISE    = 3'd4;
    localparam phase_t PH_MEASURE = 3'd5;

    logic                enable_reg;
    logic [TIME_W-1:0]   max_echo_reg;
    logic [TIME_W-1:0]   timeout_reg;

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;

    logic                out_valid_reg;
    logic                trig_reg, busy_reg, done_reg, fail_reg;
    logic                trig_next, done_next, fail_next;

    logic                accept;

    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            max_echo_reg <= MAX_ECHO_RESET;
            timeout_reg  <= START_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:        enable_reg   <= cfg_data[0];
                CFG_MAX_ECHO_TIME: max_echo_reg <= cfg_data;
                CFG_START_TIMEOUT: timeout_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // One tick of the ping sequence. The trigger phases run first; the wait
    // and measure phases then act on this tick's echo sample, so the step
    // out of the high trigger phase and into the clear wait share one tick.
    always_comb
    begin
        logic [COUNT_W-1:0] elapsed;
        elapsed        = '0;
        phase_next     = phase_reg;
        count_next     = count_reg;
        last_time_next = last_time_reg;
        trig_next      = 1'b0;
        done_next      = 1'b0;
        fail_next      = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (tick.start_req && enable_reg)
                begin
                    phase_next = PH_TLOW;
                    count_next = 17'd1;
                end
            end
            PH_TLOW:
            begin
                if (count_reg < TRIG_LOW_TICKS)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    phase_next = PH_THIGH;
                    count_next = 17'd1;
                    trig_next  = 1'b1;
                end
            end
            PH_THIGH:
            begin
                if (count_reg < TRIG_HIGH_TICKS)
                begin
                    count_next = count_reg + 1'b1;
                    trig_next  = 1'b1;
                end
                else
                begin
                    phase_next = PH_CLEAR;
                    count_next = '0;
                end
            end
            default: ;
        endcase

        if (phase_next == PH_CLEAR)
        begin
            if (tick.echo_level && (count_next <= {1'b0, timeout_reg}))
                count_next = bump(count_next);
            else
                phase_next = PH_RISE;
        end

        if (phase_next == PH_RISE)
        begin
            if (tick.echo_level)
            begin
                phase_next = PH_MEASURE;
                count_next = '0;
            end
            else if (count_next > {1'b0, timeout_reg})
            begin
                done_next = 1'b1;
                fail_next = 1'b1;
            end
            else
            begin
                count_next = bump(count_next);
            end
        end
        else if (phase_next == PH_MEASURE)
        begin
            count_next = bump(count_next);
            if (!tick.echo_level)
            begin
                done_next      = 1'b1;
                elapsed        = count_next - ECHO_OVERHEAD;
                last_time_next = (count_next > ECHO_OVERHEAD) ? elapsed[TIME_W-1:0] : '0;
            end
            else if (count_next > {1'b0, max_echo_reg})
            begin
                done_next = 1'b1;
                fail_next = 1'b1;
            end
        end

        if (done_next)
        begin
            if (fail_next)
                last_time_next = '0;
            phase_next = PH_IDLE;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                last_time_reg <= last_time_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; loaded only with an accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trig_reg <= trig_next;
            busy_reg <= (phase_next != PH_IDLE);
            done_reg <= done_next;
            fail_reg <= fail_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.trigger_level = trig_reg;
    assign result.busy_res      = busy_reg;
    assign result.done_res      = done_reg;
    assign result.no_echo       = fail_reg;
    assign result.echo_time_us  = last_time_reg;

    // A finishing item always leaves the block idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.done_res |-> !result.busy_res)
        else $error("done reported while still busy");

    // A timed-out ping reports zero as its echo time.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.no_echo |-> result.done_res && (result.echo_time_us == '0))
        else $error("no_echo without done or with a non-zero time");

    // The trigger pin is high only in the high trigger phase.
    a_trig_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && trig_next |=> phase_reg == PH_THIGH)
        else $error("trigger high outside the trigger phase");

    // Trigger phases never count past the high trigger phase's tick budget.
    a_trig_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TLOW || phase_reg == PH_THIGH) |-> count_reg <= TRIG_HIGH_TICKS)
        else $error("trigger tick counter out of range");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the ultrasonic ping / echo timer: random ticks and
// well-formed pings go in, and every result item is checked against a local predictor.
// Depends on upet_pkg, upet_tick_if, upet_result_if and ultrasonic_ping_echo_timer.

import upet_pkg::*;

typedef enum logic [PHASE_W-1:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_CLEAR,
    PH_WAIT_RISE,
    PH_MEASURE
} ping_phase_t;

typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic              no_echo;
    logic [TIME_W-1:0] echo_time_us;
} echo_reading_t;

class echo_timer_scoreboard;
    ping_phase_t        phase;
    logic [COUNT_W-1:0] ticks_in_phase;
    logic [TIME_W-1:0]  last_echo;
    bit                 enable;
    logic [TIME_W-1:0]  max_echo_us;
    logic [TIME_W-1:0]  start_timeout_us;
    echo_reading_t      expected_readings[$];
    int                 mismatches;
    int                 ticks_seen;
    int                 pings_done;
    int                 no_echoes;
    int                 reg_writes;

    function new();
        phase            = PH_IDLE;
        ticks_in_phase   = '0;
        last_echo        = '0;
        enable           = 1'b0;
        max_echo_us      = MAX_ECHO_RESET;
        start_timeout_us = START_TIMEOUT_RESET;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        reg_writes++;
        case (idx)
            CFG_ENABLE:        enable = data[0];
            CFG_MAX_ECHO_TIME: max_echo_us = data;
            CFG_START_TIMEOUT: start_timeout_us = data;
            default: ;
        endcase
    endfunction

    // The counter stops one above the largest register value.
    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] cnt);
        return (cnt < COUNT_MAX) ? cnt + 1'b1 : COUNT_MAX;
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction

    function void note_tick(bit start, bit echo);
        echo_reading_t exp_r;
        logic          trig;
        logic          done;
        logic          fail;
        trig = 1'b0;
        done = 1'b0;
        fail = 1'b0;
        ticks_seen++;
        case (phase)
            PH_IDLE:
                if (start && enable)
                begin
                    phase          = PH_TRIG_LOW;
                    ticks_in_phase = 1;
                end
            PH_TRIG_LOW:
                if (ticks_in_phase < TRIG_LOW_TICKS)
                    ticks_in_phase++;
                else
                begin
                    phase          = PH_TRIG_HIGH;
                    ticks_in_phase = 1;
                    trig           = 1'b1;
                end
            PH_TRIG_HIGH:
                if (ticks_in_phase < TRIG_HIGH_TICKS)
                begin
                    ticks_in_phase++;
                    trig = 1'b1;
                end
                else
                begin
                    phase          = PH_WAIT_CLEAR;
                    ticks_in_phase = '0;
                end
            default: ;
        endcase

        // The wait and measure phases act on the echo sample of this very tick.
        if (phase == PH_WAIT_CLEAR)
        begin
            if (echo && ticks_in_phase <= {1'b0, start_timeout_us})
                ticks_in_phase = bump(ticks_in_phase);
            else
                phase = PH_WAIT_RISE;
        end
        if (phase == PH_WAIT_RISE && !trig)
        begin
            if (echo)
            begin
                phase          = PH_MEASURE;
                ticks_in_phase = '0;
            end
            else if (ticks_in_phase > {1'b0, start_timeout_us})
            begin
                done = 1'b1;
                fail = 1'b1;
            end
            else
                ticks_in_phase = bump(ticks_in_phase);
        end
        else if (phase == PH_MEASURE)
        begin
            ticks_in_phase = bump(ticks_in_phase);
            if (!echo)
            begin
                done      = 1'b1;
                last_echo = (ticks_in_phase > ECHO_OVERHEAD) ?
                            TIME_W'(ticks_in_phase - ECHO_OVERHEAD) : '0;
            end
            else if (ticks_in_phase > {1'b0, max_echo_us})
            begin
                done = 1'b1;
                fail = 1'b1;
            end
        end

        if (done)
        begin
            if (fail)
            begin
                last_echo = '0;
                no_echoes++;
            end
            pings_done++;
            phase          = PH_IDLE;
            ticks_in_phase = '0;
        end

        exp_r.trigger_level = trig;
        exp_r.busy_res      = (phase != PH_IDLE);
        exp_r.done_res      = done;
        exp_r.no_echo       = fail;
        exp_r.echo_time_us  = last_echo;
        expected_readings.push_back(exp_r);
    endfunction

    function void check_reading(echo_reading_t got);
        echo_reading_t exp_r;
        if (expected_readings.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result item with nothing expected: trig=%b busy=%b done=%b %s%b %s%0d",
                         got.trigger_level, got.busy_res, got.done_res, "no_echo=",
                         got.no_echo, "time=", got.echo_time_us);
            return;
        end
        exp_r = expected_readings.pop_front();
        if (got.trigger_level !== exp_r.trigger_level || got.busy_res !== exp_r.busy_res ||
            got.done_res !== exp_r.done_res || got.no_echo !== exp_r.no_echo ||
            got.echo_time_us !== exp_r.echo_time_us)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("wrong result item: expected trig=%b busy=%b done=%b no_echo=%b time=%0d",
                         exp_r.trigger_level, exp_r.busy_res, exp_r.done_res, exp_r.no_echo,
                         exp_r.echo_time_us);
                $display("                   got      trig=%b busy=%b done=%b no_echo=%b time=%0d",
                         got.trigger_level, got.busy_res, got.done_res, got.no_echo,
                         got.echo_time_us);
            end
        end
    endfunction
endclass

module tb_top;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 2000000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_data;

    bit tx_gaps;
    bit rx_gaps;
    bit stray_ok;
    int hold_left;
    int stall_left;
    int ticks_sent;

    echo_timer_scoreboard sb = new();
    echo_reading_t        seen;

    upet_tick_if   tick_ch ();
    upet_result_if result_ch ();

    ultrasonic_ping_echo_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timed out after %0d cycles", CYCLE_LIMIT);
        $display("ultrasonic_ping_echo_timer: mismatch");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off asked for by the sender.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
                sb.note_tick(tick_ch.start_req, tick_ch.echo_level);
            if (result_ch.valid && result_ch.ready)
            begin
                seen.trigger_level = result_ch.trigger_level;
                seen.busy_res      = result_ch.busy_res;
                seen.done_res      = result_ch.done_res;
                seen.no_echo       = result_ch.no_echo;
                seen.echo_time_us  = result_ch.echo_time_us;
                sb.check_reading(seen);
            end
        end
    end

    function automatic bit stray_start();
        return stray_ok && ($urandom_range(0, 15) == 0);
    endfunction

    function automatic int span(logic [TIME_W-1:0] lim, int extra);
        return (lim > 40) ? 40 : int'(lim) + extra;
    endfunction

    task automatic feed(input bit start, input bit echo);
        if (tx_gaps && $urandom_range(0, 9) == 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.start_req  <= start;
        tick_ch.echo_level <= echo;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic configure(input bit en, input logic [TIME_W-1:0] max_us,
                             input logic [TIME_W-1:0] timeout_us);
        logic [TIME_W-1:0] noise;
        noise = TIME_W'($urandom_range(0, 65535));
        // Only bit 0 of the enable register counts; the rest carries noise.
        write_reg(CFG_ENABLE, {noise[TIME_W-1:1], en});
        write_reg(CFG_MAX_ECHO_TIME, max_us);
        write_reg(CFG_START_TIMEOUT, timeout_us);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, noise);
        cfg_we <= 1'b0;
    endtask

    // Start, the rest of the trigger, echo high while clearing, low, then the pulse.
    task automatic send_ping(input int clear_len, input int gap_len, input int pulse_len);
        feed(1'b1, 1'($urandom_range(0, 1)));
        repeat (13) feed(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (clear_len) feed(stray_start(), 1'b1);
        repeat (gap_len) feed(stray_start(), 1'b0);
        repeat (pulse_len) feed(stray_start(), 1'b1);
        repeat (2) feed(1'b0, 1'b0);
    endtask

    initial
    begin
        bit                en;
        bit                held_off;
        logic [TIME_W-1:0] max_us;
        logic [TIME_W-1:0] to_us;
        int                n_pings;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_ENABLE;
        cfg_data           <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.start_req  <= 1'b0;
        tick_ch.echo_level <= 1'b0;
        tx_gaps  = 1'b0;
        rx_gaps  = 1'b0;
        stray_ok = 1'b1;
        held_off = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A start while disabled is ignored.
        feed(1'b1, 1'b1);
        feed(1'b0, 1'b0);
        drain_results();
        configure(1'b1, '0, '0);
        // Starts during the trigger are ignored, and so is clearing enable mid-ping.
        feed(1'b1, 1'b0);
        repeat (3) feed(1'b1, 1'b1);
        drain_results();
        write_reg(CFG_ENABLE, '0);
        cfg_we <= 1'b0;
        repeat (10) feed(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        // With a zero deadline and no echo the ping gives up as soon as its counter passes zero.
        repeat (3) feed(1'b0, 1'b0);

        while (ticks_sent < ITEM_TARGET)
        begin
            drain_results();
            en = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 7))
                0:       max_us = '0;
                1:       max_us = '1;
                default: max_us = TIME_W'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 7))
                0:       to_us = '0;
                1:       to_us = '1;
                default: to_us = TIME_W'($urandom_range(1, 30));
            endcase
            configure(en, max_us, to_us);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            if (!held_off)
            begin
                // Results back up while the sender keeps going.
                hold_left = 80;
                held_off  = 1'b1;
            end
            repeat ($urandom_range(0, 12))
                feed(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            n_pings = $urandom_range(1, 4);
            repeat (n_pings)
                send_ping($urandom_range(0, span(to_us, 3)), $urandom_range(0, span(to_us, 3)),
                          $urandom_range(0, span(max_us, 4)));
        end

        // Widest register settings, no idling on either side.
        drain_results();
        tx_gaps  = 1'b0;
        rx_gaps  = 1'b0;
        stray_ok = 1'b0;
        configure(1'b1, '1, '1);
        send_ping(25, 6, 40);
        send_ping(0, 30, 3);

        drain_results();
        repeat (4) @(posedge clk);
        $display("%0d ticks checked over %0d register writes; %0d pings finished, %0d without echo",
                 sb.ticks_seen, sb.reg_writes, sb.pings_done, sb.no_echoes);
        $display("%0d mismatches, %0d result items still expected", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ultrasonic_ping_echo_timer: match");
        else
            $display("ultrasonic_ping_echo_timer: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
src/upet_pkg.sv
src/upet_tick_if.sv
src/upet_result_if.sv
src/ultrasonic_ping_echo_timer.sv
sim/tb_top.sv
